>>> design/wavup_pkg.sv
// ----------------------------------------------------------------------------
// wavup_pkg
// Shared types and constants for the WAV stream to oversampled DAC block.
// ----------------------------------------------------------------------------
package wavup_pkg;

  localparam int UPSAMPLE_FACTOR_DEF = 4;
  localparam int JOBQ_DEPTH_DEF      = 4;

  // Reciprocal precision for the divide-by-factor; exact for factor <= 16.
  localparam int RECIP_SHIFT = 20;

  localparam logic [2:0] ST_SAMPLE  = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOTWAVE = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_FMTCUT  = 3'd4;
  localparam logic [2:0] ST_WIDTH   = 3'd5;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
    logic       stream_end;
  } wav_in_t;

  typedef struct packed {
    logic [7:0] dac_level;
    logic [2:0] status;
    logic       last;
  } dac_out_t;

  // One job per input byte that causes results: optional level, optional status.
  typedef struct packed {
    logic       has_level;
    logic [7:0] prev_level;
    logic [7:0] level;
    logic       has_status;
    logic [2:0] status;
  } job_t;

endpackage

>>> design/wav_stream_to_oversampled_dac.sv
// ----------------------------------------------------------------------------
// wav_stream_to_oversampled_dac
// WAV byte stream parser with linear-interpolating upsampler to 8-bit levels.
// ----------------------------------------------------------------------------
//  channel   | handshake            | beat
//  ----------+----------------------+-------------------------------------
//  wav_in    | push / full          | data_byte, stream_start, stream_end
//  dac_out   | empty / pop          | dac_level, status, last
//
//  The parser takes one byte per cycle while full is low. Each sample level
//  gives UPSAMPLE_FACTOR points (one point per cycle out of the interpolator
//  while the output beat is free or popped), a status one more beat; the job
//  queue absorbs bursts. Synchronous reset clears parser, queue and output stage.
//  full rises only when the job queue is full; a stalled pop holds the beat.
// ----------------------------------------------------------------------------
module wav_stream_to_oversampled_dac #(
  parameter int UPSAMPLE_FACTOR = wavup_pkg::UPSAMPLE_FACTOR_DEF,
  parameter int JOBQ_DEPTH      = wavup_pkg::JOBQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  wavup_pkg::wav_in_t  wav_in,
  output logic                empty,
  input  logic                pop,
  output wavup_pkg::dac_out_t dac_out
);
  import wavup_pkg::*;

  logic take;
  logic job_push, job_valid, job_pop;
  job_t job_w, job_r;

  assign take = push && !full;

  wavup_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .beat     (wav_in),
    .job_push (job_push),
    .job      (job_w)
  );

  wavup_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_w),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_r),
    .valid   (job_valid)
  );

  wavup_interp #(
    .FACTOR (UPSAMPLE_FACTOR)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_r),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .dac_out   (dac_out)
  );

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("interpolator took a job from an empty queue");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_w.has_level || job_w.has_status))
    else $error("queued a job that yields no result");

  a_status_zero_level: assert property (@(posedge clk) disable iff (rst)
    (!empty && dac_out.status != ST_SAMPLE) |-> (dac_out.dac_level == 8'd0 && dac_out.last))
    else $error("status beat with nonzero level or without last");

endmodule

>>> design/wavup_parse.sv
// ----------------------------------------------------------------------------
// wavup_parse
// Front end: walks the RIFF/WAVE header and chunks, turns data bytes into
// levels and status codes, and queues a job for each byte that yields one.
// ----------------------------------------------------------------------------
module wavup_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  wavup_pkg::wav_in_t beat,
  output logic               job_push,
  output wavup_pkg::job_t    job
);
  import wavup_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_CHDR, PH_FMT, PH_SKIP, PH_DATA, PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [32:0] cnt, cnt_next;
  logic [31:0] tag, tag_next;
  logic [31:0] clen, clen_next;
  logic [15:0] swidth, swidth_next;
  logic        fmt_seen, fmt_seen_next;
  logic        header_ok, header_ok_next;
  logic [31:0] data_left, data_left_next;
  logic [7:0]  prev, prev_next;
  logic        primed, primed_next;
  logic        pair, pair_next;

  logic        fmt_done;
  logic        fin;
  logic [2:0]  fin_st;
  logic        lvl_valid;
  logic [7:0]  lvl;
  logic [7:0]  b;

  assign b = beat.data_byte;

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    tag_next       = tag;
    clen_next      = clen;
    swidth_next    = swidth;
    fmt_seen_next  = fmt_seen;
    header_ok_next = header_ok;
    data_left_next = data_left;
    prev_next      = prev;
    primed_next    = primed;
    pair_next      = pair;
    fmt_done       = 1'b0;
    fin            = 1'b0;
    fin_st         = ST_DONE;
    lvl_valid      = 1'b0;
    lvl            = b;
    job            = '0;

    if (beat.stream_start) begin
      phase_next     = PH_RIFF;
      cnt_next       = '0;
      tag_next       = '0;
      clen_next      = '0;
      swidth_next    = '0;
      fmt_seen_next  = 1'b0;
      header_ok_next = 1'b1;
      data_left_next = '0;
      prev_next      = '0;
      primed_next    = 1'b0;
      pair_next      = 1'b0;
    end

    unique case (phase_next)
      PH_RIFF: begin
        tag_next = {tag_next[23:0], b};
        if (cnt_next == 33'd3 && tag_next != TAG_RIFF) header_ok_next = 1'b0;
        if (cnt_next == 33'd11) begin
          if (!header_ok_next || tag_next != TAG_WAVE) begin
            fin    = 1'b1;
            fin_st = ST_NOTWAVE;
          end else begin
            phase_next = PH_CHDR;
            cnt_next   = '0;
          end
        end else begin
          cnt_next = cnt_next + 33'd1;
        end
      end
      PH_CHDR: begin
        if (cnt_next < 33'd4) begin
          tag_next = {tag_next[23:0], b};
          cnt_next = cnt_next + 33'd1;
        end else begin
          // length bytes arrive little-endian at counts 4..7
          unique case (cnt_next[1:0])
            2'd0:    clen_next = {24'd0, b};
            2'd1:    clen_next[15:8] = b;
            2'd2:    clen_next[23:16] = b;
            default: clen_next[31:24] = b;
          endcase
          if (cnt_next < 33'd7) begin
            cnt_next = cnt_next + 33'd1;
          end else begin
            cnt_next = '0;
            if (tag_next == TAG_FMT) begin
              if (clen_next == 32'd0) fmt_done = 1'b1;
              else phase_next = PH_FMT;
            end else if (tag_next == TAG_DATA) begin
              if (!fmt_seen_next) begin
                fin    = 1'b1;
                fin_st = ST_MISSING;
              end else if (swidth_next != 16'd8 && swidth_next != 16'd16) begin
                fin    = 1'b1;
                fin_st = ST_WIDTH;
              end else begin
                data_left_next = clen_next;
                pair_next      = 1'b0;
                if (clen_next == 32'd0) begin
                  fin    = 1'b1;
                  fin_st = ST_DONE;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end else begin
              // unknown chunk: skip body plus pad byte
              cnt_next = {1'b0, clen_next} + 33'(clen_next[0]);
              if (cnt_next != 33'd0) phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        if (cnt_next == 33'd14) swidth_next[7:0] = b;
        else if (cnt_next == 33'd15) swidth_next[15:8] = b;
        cnt_next = cnt_next + 33'd1;
        if (clen_next < 32'd16) begin
          if (cnt_next >= {1'b0, clen_next}) fmt_done = 1'b1;
        end else if (cnt_next >= 33'd16) begin
          fmt_done = 1'b1;
        end
      end
      PH_SKIP: begin
        if (cnt_next != 33'd0) cnt_next = cnt_next - 33'd1;
        if (cnt_next == 33'd0) phase_next = PH_CHDR;
      end
      PH_DATA: begin
        data_left_next = data_left_next - 32'd1;
        if (swidth_next == 16'd16) begin
          // low byte of a pair is dropped, high byte gives the level
          if (!pair_next) begin
            pair_next = 1'b1;
          end else begin
            pair_next = 1'b0;
            lvl_valid = 1'b1;
            lvl       = b ^ 8'h80;
          end
        end else begin
          lvl_valid = 1'b1;
        end
        if (data_left_next == 32'd0) begin
          fin    = 1'b1;
          fin_st = ST_DONE;
        end
      end
      default: ;
    endcase

    if (fmt_done) begin
      fmt_seen_next = 1'b1;
      if (clen_next < 32'd16) swidth_next = '0;
      if (clen_next > 32'd16) begin
        cnt_next   = 33'(clen_next - 32'd16);
        phase_next = PH_SKIP;
      end else begin
        cnt_next   = '0;
        phase_next = PH_CHDR;
      end
    end

    if (lvl_valid) begin
      if (!primed_next) begin
        prev_next   = lvl;
        primed_next = 1'b1;
      end
      job.has_level  = 1'b1;
      job.prev_level = prev_next;
      job.level      = lvl;
      prev_next      = lvl;
    end

    // truncated stream status, unless this byte already ended it
    if (!fin && beat.stream_end && phase_next != PH_IDLE) begin
      fin = 1'b1;
      priority case (phase_next)
        PH_RIFF: fin_st = ST_NOTWAVE;
        PH_FMT:  fin_st = ST_FMTCUT;
        PH_DATA: fin_st = ST_DONE;
        default: fin_st = ST_MISSING;
      endcase
    end

    if (fin) begin
      phase_next     = PH_IDLE;
      job.has_status = 1'b1;
      job.status     = fin_st;
    end
  end

  assign job_push = take && (job.has_level || job.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RIFF;
      cnt       <= '0;
      tag       <= '0;
      clen      <= '0;
      swidth    <= '0;
      fmt_seen  <= 1'b0;
      header_ok <= 1'b1;
      data_left <= '0;
      prev      <= '0;
      primed    <= 1'b0;
      pair      <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      tag       <= tag_next;
      clen      <= clen_next;
      swidth    <= swidth_next;
      fmt_seen  <= fmt_seen_next;
      header_ok <= header_ok_next;
      data_left <= data_left_next;
      prev      <= prev_next;
      primed    <= primed_next;
      pair      <= pair_next;
    end
  end

endmodule

>>> design/wavup_jobq.sv
// ----------------------------------------------------------------------------
// wavup_jobq
// Small job queue between parser and interpolator (DEPTH a power of two).
// ----------------------------------------------------------------------------
module wavup_jobq #(
  parameter int DEPTH = wavup_pkg::JOBQ_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  wavup_pkg::job_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output wavup_pkg::job_t rd_data,
  output logic            valid
);
  import wavup_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

>>> design/wavup_interp.sv
// ----------------------------------------------------------------------------
// wavup_interp
// Back end: expands each job with a level into FACTOR interpolated points
// and each job with a status into a status beat, one result per cycle while
// the output stage is free or popped, into a registered output stage.
module wavup_interp #(
  parameter int FACTOR = wavup_pkg::UPSAMPLE_FACTOR_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  wavup_pkg::job_t     job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output wavup_pkg::dac_out_t dac_out
);
  import wavup_pkg::*;

  localparam int KW = (FACTOR > 1) ? $clog2(FACTOR) : 1;
  localparam int XW = 8 + KW;
  localparam int RW = RECIP_SHIFT + 1;
  localparam logic [RW-1:0] RECIP = RW'((2 ** RECIP_SHIFT + FACTOR - 1) / FACTOR);
  localparam logic [KW-1:0] K_LAST = KW'(FACTOR - 1);

  typedef enum logic [1:0] {S_IDLE, S_LEVELS, S_STATUS} state_t;

  state_t        state;
  job_t          cur;
  logic [KW-1:0] k;
  logic [XW-1:0] x;       // |diff| * k
  logic [7:0]    mag;
  logic          neg;
  logic          ov;
  dac_out_t      out_q;

  logic [8:0]       diff9;
  logic [XW+RW-1:0] prod;
  logic [7:0]       q;
  logic [7:0]       lvl_val;
  logic             can_emit, emit, job_done, k_end;
  dac_out_t         res;

  always_comb begin
    diff9    = {1'b0, job.level} - {1'b0, job.prev_level};
    prod     = {{RW{1'b0}}, x} * {{XW{1'b0}}, RECIP};
    q        = prod[RECIP_SHIFT +: 8];
    lvl_val  = neg ? (cur.prev_level - q) : (cur.prev_level + q);
    k_end    = (k == K_LAST);
    can_emit = !ov || pop;
    emit     = (state != S_IDLE) && can_emit;
    job_done = emit && ((state == S_STATUS) ||
                        (state == S_LEVELS && k_end && !cur.has_status));
    job_pop  = job_valid && ((state == S_IDLE) || job_done);
    if (state == S_LEVELS) begin
      res.dac_level = lvl_val;
      res.status    = ST_SAMPLE;
      res.last      = k_end && !cur.has_status;
    end else begin
      res.dac_level = 8'd0;
      res.status    = cur.status;
      res.last      = 1'b1;
    end
  end

  assign empty   = !ov;
  assign dac_out = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      if (emit) begin
        ov    <= 1'b1;
        out_q <= res;
      end else if (pop) begin
        ov <= 1'b0;
      end

      if (job_pop) begin
        cur   <= job;
        k     <= '0;
        x     <= '0;
        mag   <= diff9[8] ? 8'(-diff9) : diff9[7:0];
        neg   <= diff9[8];
        state <= job.has_level ? S_LEVELS : S_STATUS;
      end else if (job_done) begin
        state <= S_IDLE;
      end else if (emit && state == S_LEVELS) begin
        if (k_end) begin
          state <= S_STATUS;
        end else begin
          k <= k + KW'(1);
          x <= x + XW'(mag);
        end
      end
    end
  end

endmodule
